FILE: rtl/core/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg: shared definitions for the small matrix multiply-add core
// Sizes, command and register codes, and the control and status structs.
// ----------------------------------------------------------------------------
package smma_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_BITS  = 16;
  localparam int VALUE_W    = 35;
  localparam int POS_W      = 3;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int IN_VALUE_W = 16;

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int RAM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int WIDE_W    = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

  typedef enum logic [2:0] {
    FUNC_LOAD_A = 3'd0,
    FUNC_LOAD_B = 3'd1,
    FUNC_MUL    = 3'd2,
    FUNC_ADD    = 3'd3,
    FUNC_SUB    = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_e;

  typedef struct packed {
    logic             issue;
    logic             first;
    logic             final_term;
    op_e              op;
    logic             emit;
    logic             err;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic res_vld;
    logic out_free;
  } stat_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(32'(row) * MAX_DIM + 32'(col));
  endfunction

endpackage

FILE: rtl/core/smma_ram.sv
// ----------------------------------------------------------------------------
// smma_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/smma_ctrl.sv
// ----------------------------------------------------------------------------
// smma_ctrl: command sequencer
// Decodes input transactions, writes loads into the stores and walks the
// result elements and inner terms, issuing store reads for each term.
// ----------------------------------------------------------------------------
module smma_ctrl import smma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            func_i,
  input  logic [POS_W-1:0]      row_i,
  input  logic [POS_W-1:0]      col_i,
  input  logic [IN_VALUE_W-1:0] value_i,
  input  logic [CFG_W-1:0]      rows_a_i,
  input  logic [CFG_W-1:0]      inner_dim_i,
  input  logic [CFG_W-1:0]      cols_b_i,
  input  stat_t                 stat_i,
  output ctrl_t                 ctrl_o,
  output logic                  a_we_o,
  output logic                  b_we_o,
  output logic [ADDR_W-1:0]     waddr_o,
  output logic [ELEM_BITS-1:0]  wdata_o,
  output logic                  re_o,
  output logic [ADDR_W-1:0]     raddr_a_o,
  output logic [ADDR_W-1:0]     raddr_b_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_ERR   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  op_e              op_q, op_d;

  logic [DIM_W-1:0] m_dim, n_dim, p_dim, terms, ncols;
  logic             accept, load_ok, row_last, col_last, term_last, emit;

  always_comb begin
    m_dim     = eff_dim(rows_a_i);
    n_dim     = eff_dim(inner_dim_i);
    p_dim     = eff_dim(cols_b_i);
    terms     = (op_q == OP_MUL) ? n_dim : DIM_W'(1);
    ncols     = (op_q == OP_MUL) ? p_dim : n_dim;
    row_last  = (DIM_W'(i_q) == m_dim - DIM_W'(1));
    col_last  = (DIM_W'(j_q) == ncols - DIM_W'(1));
    term_last = (DIM_W'(k_q) == terms - DIM_W'(1));

    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    load_ok    = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
    a_we_o     = accept && load_ok && (func_i == FUNC_LOAD_A);
    b_we_o     = accept && load_ok && (func_i == FUNC_LOAD_B);
    waddr_o    = elem_addr(IDX_W'(row_i), IDX_W'(col_i));
    wdata_o    = ELEM_BITS'($signed(value_i));

    re_o = (state_q == ST_ISSUE);
    if (op_q == OP_MUL) begin
      raddr_a_o = elem_addr(i_q, k_q);
      raddr_b_o = elem_addr(k_q, j_q);
    end else begin
      raddr_a_o = elem_addr(i_q, j_q);
      raddr_b_o = elem_addr(i_q, j_q);
    end

    emit = ((state_q == ST_WAIT) && stat_i.res_vld && stat_i.out_free) ||
           ((state_q == ST_ERR) && stat_i.out_free);

    ctrl_o.issue      = re_o;
    ctrl_o.first      = (k_q == '0);
    ctrl_o.final_term = term_last;
    ctrl_o.op         = op_q;
    ctrl_o.emit       = emit;
    ctrl_o.err        = (state_q == ST_ERR);
    ctrl_o.row        = POS_W'(i_q);
    ctrl_o.col        = POS_W'(j_q);
    ctrl_o.last       = (state_q == ST_ERR) || (row_last && col_last);
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (accept) begin
          case (func_i)
            FUNC_MUL: begin
              op_d    = OP_MUL;
              state_d = ST_ISSUE;
            end
            FUNC_ADD, FUNC_SUB: begin
              op_d    = (func_i == FUNC_ADD) ? OP_ADD : OP_SUB;
              state_d = ((m_dim == n_dim) && (n_dim == p_dim)) ? ST_ISSUE : ST_ERR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (term_last) begin
          k_d     = '0;
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (emit) begin
          if (row_last && col_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (col_last) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      op_q    <= OP_MUL;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: rtl/core/smma_mac.sv
// ----------------------------------------------------------------------------
// smma_mac: term datapath, accumulator and output register
// Forms each term from the store read data, sums the terms of one element
// and holds finished elements in the output register.
// ----------------------------------------------------------------------------
module smma_mac import smma_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic [ELEM_BITS-1:0] rdata_a_i,
  input  logic [ELEM_BITS-1:0] rdata_b_i,
  output stat_t                stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [POS_W-1:0]     out_row_o,
  output logic [POS_W-1:0]     out_col_o,
  output logic [VALUE_W-1:0]   out_value_o,
  output logic                 out_last_o,
  output logic                 out_err_o
);

  logic               s1_vld_q, s1_first_q, s1_final_q;
  op_e                s1_op_q;
  logic               s2_vld_q, s2_first_q, s2_final_q;
  logic [VALUE_W-1:0] term_q, term_d, acc_q;
  logic               res_vld_q, out_valid_q;
  logic [POS_W-1:0]   out_row_q, out_col_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_last_q, out_err_q;

  logic signed [ELEM_BITS-1:0] a_s, b_s;
  logic signed [PROD_W-1:0]    prod_full;
  logic signed [WIDE_W-1:0]    prod_w, sum_w, diff_w;

  always_comb begin
    a_s       = $signed(rdata_a_i);
    b_s       = $signed(rdata_b_i);
    prod_full = a_s * b_s;
    prod_w    = WIDE_W'(prod_full);
    sum_w     = WIDE_W'(a_s) + WIDE_W'(b_s);
    diff_w    = WIDE_W'(a_s) - WIDE_W'(b_s);
    case (s1_op_q)
      OP_MUL:  term_d = prod_w[VALUE_W-1:0];
      OP_ADD:  term_d = sum_w[VALUE_W-1:0];
      OP_SUB:  term_d = diff_w[VALUE_W-1:0];
      default: term_d = '0;
    endcase
    stat_o.res_vld  = res_vld_q;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      res_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_vld_q <= ctrl_i.issue;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q && s2_final_q) begin
        res_vld_q <= 1'b1;
      end else if (ctrl_i.emit && !ctrl_i.err) begin
        res_vld_q <= 1'b0;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= ctrl_i.first;
    s1_final_q <= ctrl_i.final_term;
    s1_op_q    <= ctrl_i.op;
    s2_first_q <= s1_first_q;
    s2_final_q <= s1_final_q;
    term_q     <= term_d;
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? term_q : acc_q + term_q;
    end
    if (ctrl_i.emit) begin
      out_row_q   <= ctrl_i.err ? '0 : ctrl_i.row;
      out_col_q   <= ctrl_i.err ? '0 : ctrl_i.col;
      out_value_q <= ctrl_i.err ? '0 : acc_q;
      out_last_q  <= ctrl_i.last;
      out_err_q   <= ctrl_i.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

FILE: rtl/core/small_matrix_multiply_add_core.sv
// ----------------------------------------------------------------------------
// small_matrix_multiply_add_core: integer matrix multiply, add and subtract
// Load transactions fill matrices A and B; command transactions stream out
// A*B, A+B or A-B in row-major order.
// ----------------------------------------------------------------------------
// A load transaction writes one element into the A or B store. A multiply
// command reads both stores once per inner term through one read port each
// and sums the terms serially; add and subtract read one element of each
// store per result element. The input is not ready while a command runs.
// An add or subtract on matrices of different shape gives a single
// transaction with tuser set and tlast high.
module small_matrix_multiply_add_core import smma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // func[2:0], elem_row[5:3], elem_col[8:6], elem_value[24:9]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_row[2:0], out_col[5:3], out_value[40:6]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  // size_error[0]
  output logic                  m_axis_tuser_o
);

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(1);
      inner_dim_q <= CFG_W'(1);
      cols_b_q    <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_wdata_i;
        CFG_COLS_B:    cols_b_q    <= cfg_wdata_i;
        default:       rows_a_q    <= rows_a_q;
      endcase
    end
  end

  ctrl_t                ctrl;
  stat_t                stat;
  logic                 a_we, b_we, re;
  logic [ADDR_W-1:0]    waddr, raddr_a, raddr_b;
  logic [ELEM_BITS-1:0] wdata, rdata_a, rdata_b;
  logic [POS_W-1:0]     out_row, out_col;
  logic [VALUE_W-1:0]   out_value;

  smma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tdata_i[2:0]),
    .row_i       (s_axis_tdata_i[5:3]),
    .col_i       (s_axis_tdata_i[8:6]),
    .value_i     (s_axis_tdata_i[24:9]),
    .rows_a_i    (rows_a_q),
    .inner_dim_i (inner_dim_q),
    .cols_b_i    (cols_b_q),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .a_we_o      (a_we),
    .b_we_o      (b_we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b)
  );

  smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(RAM_DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(RAM_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  smma_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({out_value, out_col, out_row});

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("Size error transaction is not a lone zero element.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !stat.res_vld)
    else $error("Input ready while an element result is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_we || b_we) |-> (!re && !ctrl.emit))
    else $error("Store write while a command is running.");
`endif

endmodule

FILE: test/small_matrix_multiply_add_core_tb.sv
// ----------------------------------------------------------------------------
// small_matrix_multiply_add_core_tb: self-checking bench for the matrix core
// Loads elements into A and B, issues multiply, add and subtract commands over
// a range of shapes, and checks every result transaction against a matrix
// model kept inside the bench, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module small_matrix_multiply_add_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smma_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int N_ITEMS      = 280;
  localparam int MAX_WAIT     = 4;
  localparam int IDLE_PAUSE   = 16;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1_500_000;

  localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      err;
  } mat_elem_t;

  typedef struct packed {
    logic                      is_cfg;
    cfg_idx_e                  reg_sel;
    logic [CFG_W-1:0]          reg_val;
    logic [2:0]                func;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic [IN_VALUE_W-1:0]     value;
    logic                      typed;
    logic signed [VALUE_W-1:0] exp_value;
    logic                      exp_err;
  } dir_step_t;

  localparam int N_DIR = 24;
  localparam dir_step_t DIR_STEPS [N_DIR] = '{
    // cfg  register      val   func         row   col   value     typed expected      err
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_MUL,    3'd0, 3'd0, 16'h0000, 1'b1, 35'sd1073741824, 1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_ADD,    3'd7, 3'd7, 16'hFFFF, 1'b1, -35'sd65536,  1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_SUB,    3'd0, 3'd0, 16'h0000, 1'b1, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_A, 3'd0, 3'd0, 16'h7FFF, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_MUL,    3'd0, 3'd0, 16'h0000, 1'b1, -35'sd1073709056, 1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_ADD,    3'd0, 3'd0, 16'h0000, 1'b1, -35'sd1,      1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_SUB,    3'd0, 3'd0, 16'h0000, 1'b1, 35'sd65535,   1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_RSVD_5, 3'd7, 3'd7, 16'hFFFF, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_RSVD_6, 3'd0, 3'd7, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_RSVD_7, 3'd7, 3'd0, 16'h5555, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_A, 3'd7, 3'd7, 16'hFFFF, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_B, 3'd7, 3'd0, 16'h0001, 1'b0, 35'sd0,       1'b0},
    '{1'b1, CFG_ROWS_A,    4'd2, FUNC_LOAD_A, 3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_A, 3'd1, 3'd0, 16'h1234, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_ADD,    3'd0, 3'd0, 16'h0000, 1'b1, 35'sd0,       1'b1},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_SUB,    3'd5, 3'd2, 16'hAAAA, 1'b1, 35'sd0,       1'b1},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_MUL,    3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b1, CFG_ROWS_A,    4'd1, FUNC_LOAD_A, 3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b1, CFG_COLS_B,    4'd0, FUNC_LOAD_A, 3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_LOAD_B, 3'd0, 3'd0, 16'h00FF, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_ADD,    3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0},
    '{1'b0, CFG_ROWS_A,    4'd0, FUNC_SUB,    3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0,       1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;

  logic signed [IN_VALUE_W-1:0] a_mat [RAM_DEPTH];
  logic signed [IN_VALUE_W-1:0] b_mat [RAM_DEPTH];
  bit                           a_set [RAM_DEPTH];
  bit                           b_set [RAM_DEPTH];
  logic [CFG_W-1:0]             rows_reg  = 4'd1;
  logic [CFG_W-1:0]             inner_reg = 4'd1;
  logic [CFG_W-1:0]             cols_reg  = 4'd1;

  mat_elem_t pending_elems[$];
  bit        src_calm       = 1'b0;
  bit        long_hold_done = 1'b0;
  int        items_sent     = 0;
  int        commands       = 0;
  int        results_seen   = 0;
  int        size_errs      = 0;
  int        errors         = 0;

  small_matrix_multiply_add_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    return (int'(r) > MAX_DIM) ? MAX_DIM : int'(r);
  endfunction

  function automatic mat_elem_t result_of(input logic [POS_W-1:0] row,
                                          input logic [POS_W-1:0] col,
                                          input logic signed [VALUE_W-1:0] value,
                                          input logic last, input logic err);
    mat_elem_t e;
    e.row   = row;
    e.col   = col;
    e.value = value;
    e.last  = last;
    e.err   = err;
    return e;
  endfunction

  function automatic string fmt_elem(input mat_elem_t e);
    return $sformatf("row %0d col %0d value %0d last %0b size_error %0b",
                     e.row, e.col, e.value, e.last, e.err);
  endfunction

  function automatic logic [IN_VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return IN_VALUE_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return CFG_W'($urandom_range(1, 3));
    if (roll < 8) return CFG_W'($urandom_range(4, MAX_DIM));
    if (roll < 9) return '0;
    return CFG_W'($urandom_range(MAX_DIM + 1, 15));
  endfunction

  task automatic compute_matrix_op(input logic [2:0] func, input logic [POS_W-1:0] row,
                                   input logic [POS_W-1:0] col,
                                   input logic [IN_VALUE_W-1:0] value);
    int m;
    int n;
    int p;
    logic signed [VALUE_W-1:0] acc;
    m = clamp_dim(rows_reg);
    n = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    case (func)
      FUNC_LOAD_A: begin
        a_mat[row * MAX_DIM + col] = value;
        a_set[row * MAX_DIM + col] = 1'b1;
      end
      FUNC_LOAD_B: begin
        b_mat[row * MAX_DIM + col] = value;
        b_set[row * MAX_DIM + col] = 1'b1;
      end
      FUNC_MUL: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              acc = acc + a_mat[i * MAX_DIM + k] * b_mat[k * MAX_DIM + j];
            end
            pending_elems.push_back(result_of(POS_W'(i), POS_W'(j), acc,
                                              (i == m - 1) && (j == p - 1), 1'b0));
          end
        end
      end
      FUNC_ADD, FUNC_SUB: begin
        if (!(m == n && n == p)) begin
          pending_elems.push_back(result_of('0, '0, '0, 1'b1, 1'b1));
        end else begin
          for (int i = 0; i < m; i++) begin
            for (int j = 0; j < m; j++) begin
              acc = a_mat[i * MAX_DIM + j];
              acc = (func == FUNC_ADD) ? acc + b_mat[i * MAX_DIM + j]
                                       : acc - b_mat[i * MAX_DIM + j];
              pending_elems.push_back(result_of(POS_W'(i), POS_W'(j), acc,
                                                (i == m - 1) && (j == m - 1), 1'b0));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [2:0] func, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic [IN_VALUE_W-1:0] value);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({value, col, row, func});
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    if (func <= FUNC_SUB) items_sent++;
    if (func >= FUNC_MUL && func <= FUNC_SUB) commands++;
  endtask

  task automatic issue(input logic [2:0] func, input logic [POS_W-1:0] row,
                       input logic [POS_W-1:0] col, input logic [IN_VALUE_W-1:0] value);
    send_item(func, row, col, value);
    compute_matrix_op(func, row, col, value);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_ROWS_A:    rows_reg  = val;
      CFG_INNER_DIM: inner_reg = val;
      CFG_COLS_B:    cols_reg  = val;
      default: ;
    endcase
  endtask

  task automatic fill_operands(input logic [2:0] func);
    int m;
    int n;
    int p;
    m = clamp_dim(rows_reg);
    n = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    if (func == FUNC_MUL) begin
      for (int i = 0; i < m; i++)
        for (int k = 0; k < n; k++)
          if (!a_set[i * MAX_DIM + k]) issue(FUNC_LOAD_A, POS_W'(i), POS_W'(k), rand_value());
      for (int k = 0; k < n; k++)
        for (int j = 0; j < p; j++)
          if (!b_set[k * MAX_DIM + j]) issue(FUNC_LOAD_B, POS_W'(k), POS_W'(j), rand_value());
    end else if (m == n && n == p) begin
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < m; j++) begin
          if (!a_set[i * MAX_DIM + j]) issue(FUNC_LOAD_A, POS_W'(i), POS_W'(j), rand_value());
          if (!b_set[i * MAX_DIM + j]) issue(FUNC_LOAD_B, POS_W'(i), POS_W'(j), rand_value());
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    mat_elem_t got;
    mat_elem_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1) begin
      got = result_of(m_axis_tdata_o[POS_W-1:0], m_axis_tdata_o[POS_W +: POS_W],
                      m_axis_tdata_o[2*POS_W +: VALUE_W], m_axis_tlast_o, m_axis_tuser_o);
      results_seen++;
      if (got.err) size_errs++;
      if (pending_elems.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got %s", $time, fmt_elem(got));
      end else begin
        want = pending_elems.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %s", $time, fmt_elem(want));
          $display("%0t:           got      %s", $time, fmt_elem(got));
        end
      end
    end
  end

  initial begin : sink
    int hold;
    int calm_left;
    calm_left = 0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && pending_elems.size() > 16 && s_axis_tvalid_i === 1'b1) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (calm_left > 0) begin
        hold = 0;
        calm_left--;
      end else begin
        hold = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 24) == 0) calm_left = 40;
      end
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int m;
    int n;
    int p;
    logic [2:0] cmd;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_ROWS_A;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_STEPS[s]) begin
      if (DIR_STEPS[s].is_cfg) begin
        write_reg(DIR_STEPS[s].reg_sel, DIR_STEPS[s].reg_val);
      end else if (DIR_STEPS[s].typed) begin
        send_item(DIR_STEPS[s].func, DIR_STEPS[s].row, DIR_STEPS[s].col, DIR_STEPS[s].value);
        pending_elems.push_back(result_of('0, '0, DIR_STEPS[s].exp_value, 1'b1,
                                          DIR_STEPS[s].exp_err));
      end else begin
        issue(DIR_STEPS[s].func, DIR_STEPS[s].row, DIR_STEPS[s].col, DIR_STEPS[s].value);
      end
    end

    phase = 0;
    while (items_sent < N_ITEMS) begin
      // The first two shapes push the registers to zero and past the maximum.
      if (phase == 0) begin
        write_reg(CFG_ROWS_A, 4'd15);
        write_reg(CFG_INNER_DIM, 4'd0);
        write_reg(CFG_COLS_B, 4'd9);
      end else if (phase == 1) begin
        write_reg(CFG_ROWS_A, 4'd0);
        write_reg(CFG_INNER_DIM, 4'd15);
        write_reg(CFG_COLS_B, 4'd0);
      end else if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_ROWS_A, pick_dim());
        write_reg(CFG_INNER_DIM, rows_reg);
        write_reg(CFG_COLS_B, rows_reg);
      end else begin
        write_reg(CFG_ROWS_A, pick_dim());
        write_reg(CFG_INNER_DIM, pick_dim());
        write_reg(CFG_COLS_B, pick_dim());
      end
      m = clamp_dim(rows_reg);
      n = clamp_dim(inner_reg);
      p = clamp_dim(cols_reg);
      src_calm = ($urandom_range(0, 4) == 0);

      // The first shape runs a long product with a second command queued behind it.
      repeat ((phase == 0) ? 2 : $urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 7) == 0) begin
            issue(3'($urandom_range(FUNC_RSVD_5, FUNC_RSVD_7)), POS_W'($urandom()),
                  POS_W'($urandom()), rand_value());
          end else if ($urandom_range(0, 3) == 0) begin
            issue(3'($urandom_range(FUNC_LOAD_A, FUNC_LOAD_B)), POS_W'($urandom()),
                  POS_W'($urandom()), rand_value());
          end else if ($urandom_range(0, 1) == 0) begin
            issue(FUNC_LOAD_A, POS_W'($urandom_range(0, m - 1)),
                  POS_W'($urandom_range(0, n - 1)), rand_value());
          end else begin
            issue(FUNC_LOAD_B, POS_W'($urandom_range(0, n - 1)),
                  POS_W'($urandom_range(0, p - 1)), rand_value());
          end
        end
        if (phase == 0) begin
          cmd = FUNC_MUL;
        end else if (m == n && n == p) begin
          cmd = 3'($urandom_range(FUNC_MUL, FUNC_SUB));
        end else if ($urandom_range(0, 4) == 0) begin
          cmd = 3'($urandom_range(FUNC_ADD, FUNC_SUB));
        end else begin
          cmd = FUNC_MUL;
        end
        fill_operands(cmd);
        issue(cmd, POS_W'($urandom()), POS_W'($urandom()), rand_value());
      end
      phase++;
    end

    settle();
    $display("Ran %0d load and command transactions, %0d of them commands, over %0d shapes.",
             items_sent, commands, phase);
    $display("Checked %0d result transactions, %0d of them size errors; %0d mismatches.",
             results_seen, size_errs, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
